// ----- rtl/rrfp_pkg.sv -----
// Shared constants, types and the CRC step for the reader response frame parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrfp_pkg;

    localparam int FRAME_BYTES   = 255;
    localparam int MAX_EPC_BYTES = 32;

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int CNT_W  = $clog2(MAX_EPC_BYTES + 1);
    localparam int IDX_W  = 14;
    localparam int CLS_W  = 3;

    localparam logic [7:0]  HEADER_BYTE = 8'hFF;
    localparam logic [7:0]  OP_TAG      = 8'h22;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic [15:0] ST_KEEPALIVE = 16'h0400;
    localparam logic [15:0] ST_THROTTLE  = 16'h0504;
    localparam logic [15:0] ST_RETLOSS   = 16'h0505;
    localparam logic [7:0]  LEN_STATUS   = 8'h08;
    localparam logic [7:0]  LEN_TEMP     = 8'h0A;

    localparam int CRC_LAST_OFS  = 4;
    localparam int CRC_HI_OFS    = 5;
    localparam int FRAME_OVERHD  = 7;
    localparam int EBITS_OFS     = 27;
    localparam int EPC_OFS       = 31;

    localparam logic [ADDR_W-1:0] POS_HDR   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] POS_LEN   = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] POS_OP    = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] POS_ST_HI = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] POS_ST_LO = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] POS_RSSI  = ADDR_W'(12);
    localparam logic [ADDR_W-1:0] POS_FRQ2  = ADDR_W'(14);
    localparam logic [ADDR_W-1:0] POS_FRQ1  = ADDR_W'(15);
    localparam logic [ADDR_W-1:0] POS_FRQ0  = ADDR_W'(16);
    localparam logic [ADDR_W-1:0] POS_TS3   = ADDR_W'(17);
    localparam logic [ADDR_W-1:0] POS_TS2   = ADDR_W'(18);
    localparam logic [ADDR_W-1:0] POS_TS1   = ADDR_W'(19);
    localparam logic [ADDR_W-1:0] POS_TS0   = ADDR_W'(20);
    localparam logic [ADDR_W-1:0] POS_TL1   = ADDR_W'(24);
    localparam logic [ADDR_W-1:0] POS_TL0   = ADDR_W'(25);

    localparam logic [CLS_W-1:0] CLS_BAD_CRC   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_KEEPALIVE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_THROTTLE  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_RETLOSS   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_STATUS    = 3'd4;
    localparam logic [CLS_W-1:0] CLS_TEMP      = 3'd5;
    localparam logic [CLS_W-1:0] CLS_TAG       = 3'd6;
    localparam logic [CLS_W-1:0] CLS_UNK_OP    = 3'd7;

    typedef struct packed {
        logic [7:0]  len;
        logic [7:0]  op;
        logic [15:0] status;
        logic [7:0]  rssi;
        logic [23:0] freq;
        logic [31:0] ts;
        logic [15:0] tlen;
        logic        crc_ok;
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            top = c[15];
            c   = {c[14:0], b[i]};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rrfp_ifs.sv -----
// Valid/ready channel interfaces for received bytes and parsed results.
// Depends on rrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrfp_out_if import rrfp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CLS_W-1:0]        response_class;
    logic signed [7:0]       rssi;
    logic [23:0]             frequency;
    logic [31:0]             timestamp;
    logic [CNT_W-1:0]        epc_count;
    logic [7:0]              epc_byte;
    logic                    last;

    modport source (output valid, output response_class, output rssi, output frequency,
                    output timestamp, output epc_count, output epc_byte, output last,
                    input ready);
    modport sink   (input valid, input response_class, input rssi, input frequency,
                    input timestamp, input epc_count, input epc_byte, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/rrfp_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rrfp_intake.sv -----
// Byte intake: header hunt, write position, running CRC and header field capture.
// Depends on rrfp_pkg; drives the write port of the frame RAM.
`timescale 1ns / 1ps
`default_nettype none

module rrfp_intake import rrfp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              beat,
    input  wire logic [7:0]        rx_byte,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [7:0]             wr_data,
    output logic                   frame_done,
    output frame_t                 frame
);

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              hi_ok_reg, hi_ok_next;
    frame_t            frame_reg, frame_next;

    logic              hunting;
    logic              store;
    logic [7:0]        len_cur;
    logic [LEN_W-1:0]  pos9;
    logic [LEN_W-1:0]  len9;

    assign hunting = (pos_reg == POS_HDR);
    assign store   = beat && (!hunting || rx_byte == HEADER_BYTE);
    assign len_cur = (pos_reg == POS_LEN) ? rx_byte : frame_reg.len;
    assign pos9    = {1'b0, pos_reg};
    assign len9    = {1'b0, len_cur};

    assign frame_done = store && !hunting && pos_reg != ADDR_W'(FRAME_BYTES - 1)
                        && (pos9 + 1'b1) == (len9 + LEN_W'(FRAME_OVERHD));

    assign wr_en   = store;
    assign wr_addr = pos_reg;
    assign wr_data = rx_byte;
    assign frame   = frame_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        hi_ok_next = hi_ok_reg;
        frame_next = frame_reg;
        if (store)
        begin
            pos_next = (frame_done || pos_reg == ADDR_W'(FRAME_BYTES - 1)) ?
                       POS_HDR : pos_reg + 1'b1;
            if (hunting)
            begin
                frame_next = '0;
                crc_next   = CRC_INIT;
                hi_ok_next = 1'b0;
            end
            else
            begin
                if (pos9 <= len9 + LEN_W'(CRC_LAST_OFS))
                begin
                    crc_next = crc_byte(crc_reg, rx_byte);
                end
                if (pos9 == len9 + LEN_W'(CRC_HI_OFS))
                begin
                    hi_ok_next = (rx_byte == crc_reg[15:8]);
                end
                if (frame_done)
                begin
                    frame_next.crc_ok = hi_ok_reg && (rx_byte == crc_reg[7:0]);
                end
                case (pos_reg)
                    POS_LEN:   frame_next.len          = rx_byte;
                    POS_OP:    frame_next.op           = rx_byte;
                    POS_ST_HI: frame_next.status[15:8] = rx_byte;
                    POS_ST_LO: frame_next.status[7:0]  = rx_byte;
                    POS_RSSI:  frame_next.rssi         = rx_byte;
                    POS_FRQ2:  frame_next.freq[23:16]  = rx_byte;
                    POS_FRQ1:  frame_next.freq[15:8]   = rx_byte;
                    POS_FRQ0:  frame_next.freq[7:0]    = rx_byte;
                    POS_TS3:   frame_next.ts[31:24]    = rx_byte;
                    POS_TS2:   frame_next.ts[23:16]    = rx_byte;
                    POS_TS1:   frame_next.ts[15:8]     = rx_byte;
                    POS_TS0:   frame_next.ts[7:0]      = rx_byte;
                    POS_TL1:   frame_next.tlen[15:8]   = rx_byte;
                    POS_TL0:   frame_next.tlen[7:0]    = rx_byte;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HDR;
            crc_reg   <= CRC_INIT;
            hi_ok_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            hi_ok_reg <= hi_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

`default_nettype wire

// ----- rtl/rrfp_seq.sv -----
// Frame-end sequencer: classification, EPC length and EPC byte reads from the
// frame RAM, and the output register. Depends on rrfp_pkg and rrfp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rrfp_seq import rrfp_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              frame_done,
    input  wire frame_t            frame,
    input  wire logic [7:0]        rd_q,
    output logic                   rd_en,
    output logic [ADDR_W-1:0]      rd_addr,
    output logic                   idle,
    rrfp_out_if.source             resp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_EHI   = 3'd2;
    localparam logic [2:0] ST_ELO   = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_ONE   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [IDX_W-1:0] d_reg, d_next;
    logic [7:0]       ehi_reg, ehi_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] x_reg, x_next;
    logic             ok_reg;

    logic             out_valid_reg, out_valid_next;
    logic [CLS_W-1:0] out_cls_reg;
    logic [7:0]       out_rssi_reg;
    logic [23:0]      out_freq_reg;
    logic [31:0]      out_ts_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [7:0]       out_epc_reg;
    logic             out_last_reg;

    logic [CLS_W-1:0] cls_calc;
    logic [16:0]      tlen_up;
    logic [IDX_W-1:0] d_calc;
    logic [LEN_W-1:0] frame_end;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_ok;
    logic [7:0]       rd_byte;
    logic [12:0]      ebytes;
    logic [12:0]      ebytes_net;
    logic [CNT_W-1:0] n_calc;
    logic             slot_free;
    logic             load;
    logic             load_tag;
    logic [CLS_W-1:0] load_cls;
    logic [7:0]       load_epc;
    logic             load_last;

    always_comb
    begin
        if (!frame.crc_ok)
        begin
            cls_calc = CLS_BAD_CRC;
        end
        else if (frame.op != OP_TAG)
        begin
            cls_calc = CLS_UNK_OP;
        end
        else if (frame.len == 8'd0)
        begin
            if (frame.status == ST_KEEPALIVE)
            begin
                cls_calc = CLS_KEEPALIVE;
            end
            else if (frame.status == ST_THROTTLE)
            begin
                cls_calc = CLS_THROTTLE;
            end
            else if (frame.status == ST_RETLOSS)
            begin
                cls_calc = CLS_RETLOSS;
            end
            else
            begin
                cls_calc = CLS_STATUS;
            end
        end
        else if (frame.len == LEN_STATUS)
        begin
            cls_calc = CLS_STATUS;
        end
        else if (frame.len == LEN_TEMP)
        begin
            cls_calc = CLS_TEMP;
        end
        else
        begin
            cls_calc = CLS_TAG;
        end
    end

    assign tlen_up   = {1'b0, frame.tlen} + 17'd7;
    assign d_calc    = tlen_up[16:3];
    assign frame_end = {1'b0, frame.len} + LEN_W'(FRAME_OVERHD);

    always_comb
    begin
        case (state_reg)
            ST_CLASS: rd_idx = d_calc + IDX_W'(EBITS_OFS);
            ST_EHI:   rd_idx = d_reg + IDX_W'(EBITS_OFS + 1);
            ST_RD:    rd_idx = d_reg + IDX_W'(EPC_OFS) + IDX_W'(x_reg);
            default:  rd_idx = '0;
        endcase
    end

    assign rd_ok   = rd_idx < IDX_W'(frame_end);
    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign rd_en   = (state_reg == ST_CLASS && cls_calc == CLS_TAG)
                     || state_reg == ST_EHI || state_reg == ST_RD;
    assign rd_byte = ok_reg ? rd_q : 8'd0;

    assign ebytes     = {ehi_reg, rd_byte[7:3]};
    assign ebytes_net = ebytes - 13'd4;
    always_comb
    begin
        if (ebytes <= 13'd4)
        begin
            n_calc = '0;
        end
        else if (ebytes_net > 13'(MAX_EPC_BYTES))
        begin
            n_calc = CNT_W'(MAX_EPC_BYTES);
        end
        else
        begin
            n_calc = ebytes_net[CNT_W-1:0];
        end
    end

    assign slot_free = !out_valid_reg || resp.ready;
    assign load      = slot_free && (state_reg == ST_EMIT || state_reg == ST_ONE);
    assign load_tag  = (state_reg == ST_EMIT) || (cls_reg == CLS_TAG);
    assign load_cls  = (state_reg == ST_EMIT) ? CLS_TAG : cls_reg;
    assign load_epc  = (state_reg == ST_EMIT) ? rd_byte : 8'd0;
    assign load_last = (state_reg == ST_ONE) || (x_reg + 1'b1 == n_reg);

    always_comb
    begin
        state_next = state_reg;
        cls_next   = cls_reg;
        d_next     = d_reg;
        ehi_next   = ehi_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                cls_next   = cls_calc;
                d_next     = d_calc;
                n_next     = '0;
                state_next = (cls_calc == CLS_TAG) ? ST_EHI : ST_ONE;
            end
            ST_EHI:
            begin
                ehi_next   = rd_byte;
                state_next = ST_ELO;
            end
            ST_ELO:
            begin
                n_next     = n_calc;
                x_next     = '0;
                state_next = (n_calc == '0) ? ST_ONE : ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    x_next     = x_reg + 1'b1;
                    state_next = load_last ? ST_IDLE : ST_RD;
                end
            end
            ST_ONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
        d_reg   <= d_next;
        ehi_reg <= ehi_next;
        n_reg   <= n_next;
        x_reg   <= x_next;
        if (rd_en)
        begin
            ok_reg <= rd_ok;
        end
        if (load)
        begin
            out_cls_reg  <= load_cls;
            out_rssi_reg <= load_tag ? frame.rssi : 8'd0;
            out_freq_reg <= load_tag ? frame.freq : 24'd0;
            out_ts_reg   <= load_tag ? frame.ts : 32'd0;
            out_cnt_reg  <= n_reg;
            out_epc_reg  <= load_epc;
            out_last_reg <= load_last;
        end
    end

    assign idle                = (state_reg == ST_IDLE);
    assign resp.valid          = out_valid_reg;
    assign resp.response_class = out_cls_reg;
    assign resp.rssi           = $signed(out_rssi_reg);
    assign resp.frequency      = out_freq_reg;
    assign resp.timestamp      = out_ts_reg;
    assign resp.epc_count      = out_cnt_reg;
    assign resp.epc_byte       = out_epc_reg;
    assign resp.last           = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/reader_response_frame_parser.sv -----
// Reader response frame parser: one byte beat per cycle while idle. After the frame's
// last byte the sequencer holds rx off: a single result goes through the CLASS and ONE
// states before it is registered; a tag frame reads its EPC length in the CLASS, EHI and
// ELO states, then does one RAM read per EPC byte (states RD and EMIT), or goes to ONE
// when it has none. A stalled result holds the sequencer and rx.
// Reset clears the write position, CRC and sequencer; the frame RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module reader_response_frame_parser import rrfp_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rrfp_in_if.sink    rx,
    rrfp_out_if.source resp
);

    logic              beat;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_q;
    logic              frame_done;
    frame_t            frame;
    logic              idle;

    assign rx.ready = idle;
    assign beat     = rx.valid && idle;

    rrfp_intake u_intake (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .rx_byte    (rx.rx_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .frame_done (frame_done),
        .frame      (frame)
    );

    rrfp_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_q)
    );

    rrfp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_done (frame_done),
        .frame      (frame),
        .rd_q       (rd_q),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .idle       (idle),
        .resp       (resp)
    );

endmodule

`default_nettype wire

// ----- rtl/rrfp_checker.sv -----
// Port-level checks for the reader response frame parser, bound to the top level.
// Depends on rrfp_pkg and reader_response_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

module rrfp_checker import rrfp_pkg::*; (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    rx_ready,
    input wire logic                    resp_valid,
    input wire logic                    resp_ready,
    input wire logic [CLS_W-1:0]        response_class,
    input wire logic signed [7:0]       rssi,
    input wire logic [23:0]             frequency,
    input wire logic [31:0]             timestamp,
    input wire logic [CNT_W-1:0]        epc_count,
    input wire logic [7:0]              epc_byte,
    input wire logic                    last
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid && $stable(response_class)
            && $stable(epc_byte) && $stable(epc_count) && $stable(last))
        else $error("result beat changed while stalled");

    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && response_class != CLS_TAG |-> last && epc_count == '0
            && rssi == 8'sd0 && frequency == 24'd0 && timestamp == 32'd0)
        else $error("non-tag result carries tag fields");

    a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !last |-> !rx_ready)
        else $error("rx accepted while EPC results pending");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> epc_count <= CNT_W'(MAX_EPC_BYTES))
        else $error("EPC count above limit");

endmodule

bind reader_response_frame_parser rrfp_checker u_rrfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_ready       (rx.ready),
    .resp_valid     (resp.valid),
    .resp_ready     (resp.ready),
    .response_class (resp.response_class),
    .rssi           (resp.rssi),
    .frequency      (resp.frequency),
    .timestamp      (resp.timestamp),
    .epc_count      (resp.epc_count),
    .epc_byte       (resp.epc_byte),
    .last           (resp.last)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for reader_response_frame_parser: byte frames in, parsed results out.
// Depends on rrfp_pkg, rrfp_ifs and the parser RTL; predicts each result from accepted beats.
`timescale 1ns / 1ps

module tb_top;
    import rrfp_pkg::*;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [7:0]       rssi;
        logic [23:0]      freq;
        logic [31:0]      ts;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       epc;
        logic             last;
    } parsed_result_t;

    logic clk;
    logic rst_n;

    rrfp_in_if  rx_ch ();
    rrfp_out_if resp_ch ();

    reader_response_frame_parser uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .resp  (resp_ch)
    );

    logic [7:0]     byte_q[$];
    logic [7:0]     draft[$];
    parsed_result_t pending_results[$];
    parsed_result_t want_res;

    logic [7:0]  frame_mem [FRAME_BYTES];
    int          wr_pos;
    logic [15:0] frame_crc;

    int bytes_pushed;
    int bytes_taken;
    int results_predicted;
    int results_checked;
    int fault_count;
    int send_gap;
    int send_burst;
    int recv_stall;
    int recv_burst;
    int holdoff_left;
    bit holdoff_done;

    always #5 clk = ~clk;

    function automatic logic [15:0] crc_ccitt(logic [15:0] crc, logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[15];
            r  = (r << 1) | 16'(data[k]);
            r  = r ^ (CRC_POLY & {16{fb}});
        end
        return r;
    endfunction

    function automatic int pick_idle(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Frame predictor

    function automatic logic [7:0] frame_at(int idx);
        return (idx < FRAME_BYTES) ? frame_mem[idx] : 8'h00;
    endfunction

    function automatic logic [CLS_W-1:0] classify_frame();
        int          len;
        logic [15:0] st;
        len = frame_mem[POS_LEN];
        if (frame_at(len + CRC_HI_OFS) != frame_crc[15:8] ||
            frame_at(len + CRC_HI_OFS + 1) != frame_crc[7:0])
            return CLS_BAD_CRC;
        if (frame_mem[POS_OP] != OP_TAG)
            return CLS_UNK_OP;
        if (len == 0)
        begin
            st = {frame_at(POS_ST_HI), frame_at(POS_ST_LO)};
            if (st == ST_KEEPALIVE)
                return CLS_KEEPALIVE;
            if (st == ST_THROTTLE)
                return CLS_THROTTLE;
            if (st == ST_RETLOSS)
                return CLS_RETLOSS;
            return CLS_STATUS;
        end
        if (len == LEN_STATUS)
            return CLS_STATUS;
        if (len == LEN_TEMP)
            return CLS_TEMP;
        return CLS_TAG;
    endfunction

    function automatic void absorb_byte(logic [7:0] b);
        int             pos;
        int             nxt;
        int             tbits;
        int             dlen;
        int             ebits;
        int             cnt;
        parsed_result_t res;
        pos = wr_pos;
        if (pos >= FRAME_BYTES)
            pos = 0;
        if (pos == 0 && b != HEADER_BYTE)
            return;
        frame_mem[pos] = b;
        if (pos == 0)
            frame_crc = CRC_INIT;
        else if (pos <= int'(frame_mem[POS_LEN]) + CRC_LAST_OFS)
            frame_crc = crc_ccitt(frame_crc, b);
        nxt = (pos + 1) % FRAME_BYTES;
        wr_pos = nxt;
        if (nxt == 0 || nxt != int'(frame_mem[POS_LEN]) + FRAME_OVERHD)
            return;
        for (int i = nxt; i < FRAME_BYTES; i++)
            frame_mem[i] = 8'h00;
        wr_pos = 0;
        res      = '0;
        res.cls  = classify_frame();
        res.last = 1'b1;
        if (res.cls == CLS_TAG)
        begin
            res.rssi = frame_at(POS_RSSI);
            res.freq = {frame_at(POS_FRQ2), frame_at(POS_FRQ1), frame_at(POS_FRQ0)};
            res.ts   = {frame_at(POS_TS3), frame_at(POS_TS2), frame_at(POS_TS1),
                        frame_at(POS_TS0)};
            tbits = {frame_at(POS_TL1), frame_at(POS_TL0)};
            dlen  = (tbits + 7) / 8;
            ebits = {frame_at(EBITS_OFS + dlen), frame_at(EBITS_OFS + 1 + dlen)};
            cnt   = ebits / 8;
            cnt   = (cnt > 4) ? cnt - 4 : 0;
            if (cnt > MAX_EPC_BYTES)
                cnt = MAX_EPC_BYTES;
            res.cnt = CNT_W'(cnt);
            for (int x = 0; x < cnt; x++)
            begin
                res.epc  = frame_at(EPC_OFS + dlen + x);
                res.last = (x == cnt - 1);
                pending_results.push_back(res);
                results_predicted++;
            end
            if (cnt != 0)
                return;
        end
        pending_results.push_back(res);
        results_predicted++;
    endfunction

    // Stimulus builders

    function automatic void push_byte(logic [7:0] b);
        byte_q.push_back(b);
        bytes_pushed++;
    endfunction

    function automatic void open_frame(int len, logic [7:0] op);
        draft.delete();
        draft.push_back(HEADER_BYTE);
        draft.push_back(len[7:0]);
        draft.push_back(op);
        for (int i = 3; i <= len + CRC_LAST_OFS; i++)
            draft.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void poke(int idx, logic [7:0] v);
        if (idx >= 3 && idx < draft.size())
            draft[idx] = v;
    endfunction

    function automatic void close_frame(bit corrupt);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 1; i < draft.size(); i++)
            c = crc_ccitt(c, draft[i]);
        if (corrupt)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        foreach (draft[i])
            push_byte(draft[i]);
        push_byte(c[15:8]);
        push_byte(c[7:0]);
    endfunction

    function automatic void add_plain_frame(int len, logic [7:0] op, bit corrupt);
        open_frame(len, op);
        close_frame(corrupt);
    endfunction

    function automatic void add_status_frame(logic [15:0] st, bit corrupt);
        open_frame(0, OP_TAG);
        poke(POS_ST_HI, st[15:8]);
        poke(POS_ST_LO, st[7:0]);
        close_frame(corrupt);
    endfunction

    function automatic void add_oversized(int len);
        push_byte(HEADER_BYTE);
        push_byte(len[7:0]);
        repeat (FRAME_BYTES - 2)
            push_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_tag_frame(int tbits, int ebits, int spare, bit corrupt,
                                          int fill);
        int dlen;
        int cnt;
        int len;
        dlen = (tbits + 7) / 8;
        cnt  = (ebits / 8 > 4) ? ebits / 8 - 4 : 0;
        if (cnt > MAX_EPC_BYTES + 2)
            cnt = MAX_EPC_BYTES + 2;
        len = EPC_OFS - CRC_LAST_OFS - 1 + dlen + cnt + spare;
        if (len > FRAME_BYTES - FRAME_OVERHD - 1)
            len = FRAME_BYTES - FRAME_OVERHD - 1;
        if (len <= LEN_TEMP)
            len = LEN_TEMP + 1;
        open_frame(len, OP_TAG);
        if (fill >= 0)
        begin
            for (int i = POS_RSSI; i <= POS_TS0; i++)
                poke(i, fill[7:0]);
        end
        poke(POS_TL1, tbits[15:8]);
        poke(POS_TL0, tbits[7:0]);
        poke(EBITS_OFS + dlen, ebits[15:8]);
        poke(EBITS_OFS + 1 + dlen, ebits[7:0]);
        close_frame(corrupt);
    endfunction

    function automatic void add_random_frame();
        int r;
        int k;
        int tbits;
        int ebits;
        int spare;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            k = $urandom_range(0, 99);
            tbits = (k < 75) ? $urandom_range(0, 48) :
                    (k < 95) ? 0 : $urandom_range(0, 65535);
            k = $urandom_range(0, 99);
            ebits = (k < 60) ? ($urandom_range(0, 10) + 4) * 8 + $urandom_range(0, 7) :
                    (k < 85) ? ($urandom_range(0, 36) + 4) * 8 + $urandom_range(0, 7) :
                    $urandom_range(0, 65535);
            spare = ($urandom_range(0, 99) < 15) ? -$urandom_range(1, 8) :
                    $urandom_range(0, 3);
            add_tag_frame(tbits, ebits, spare, $urandom_range(0, 9) == 0, -1);
        end
        else if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0: add_status_frame(ST_KEEPALIVE, $urandom_range(0, 9) == 0);
                1: add_status_frame(ST_THROTTLE, $urandom_range(0, 9) == 0);
                2: add_status_frame(ST_RETLOSS, $urandom_range(0, 9) == 0);
                default: add_status_frame(16'($urandom_range(0, 65535)), 1'b0);
            endcase
        end
        else if (r < 68)
            add_plain_frame($urandom_range(0, 1) ? LEN_STATUS : LEN_TEMP, OP_TAG,
                            $urandom_range(0, 9) == 0);
        else if (r < 76)
            add_plain_frame($urandom_range(0, 40), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 9) == 0);
        else if (r < 86)
            add_plain_frame($urandom_range(0, 60), OP_TAG, $urandom_range(0, 9) == 0);
        else if (r < 90)
        begin
            // drop the tail; the next header lands inside this frame
            open_frame($urandom_range(0, 30), 8'($urandom_range(0, 255)));
            k = $urandom_range(1, draft.size() - 1);
            for (int i = 0; i < k; i++)
                push_byte(draft[i]);
        end
        else if (r < 97)
        begin
            repeat ($urandom_range(1, 5))
                push_byte(8'($urandom_range(0, 254)));
        end
        else
            add_oversized($urandom_range(FRAME_BYTES - FRAME_OVERHD, 255));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // Byte driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                absorb_byte(rx_ch.rx_byte);
                bytes_taken++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    rx_ch.valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= byte_q.pop_front();
                    send_gap = pick_idle(send_burst);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_ch.ready   <= 1'b0;
            results_checked <= 0;
            recv_stall = 0;
        end
        else
        begin
            if (resp_ch.valid && resp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual class %0d byte %0h",
                             $time, resp_ch.response_class, resp_ch.epc_byte);
                    fault_count++;
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    check_field("response_class", want_res.cls, resp_ch.response_class);
                    check_field("rssi", want_res.rssi, resp_ch.rssi[7:0]);
                    check_field("frequency", want_res.freq, resp_ch.frequency);
                    check_field("timestamp", want_res.ts, resp_ch.timestamp);
                    check_field("epc_count", want_res.cnt, resp_ch.epc_count);
                    check_field("epc_byte", want_res.epc, resp_ch.epc_byte);
                    check_field("last", want_res.last, resp_ch.last);
                end
                results_checked <= results_checked + 1;
                recv_stall = pick_idle(recv_burst);
            end
            if (holdoff_left != 0)
                resp_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                resp_ch.ready <= 1'b0;
            end
            else
                resp_ch.ready <= 1'b1;
        end
    end

    // Long receiver hold-off: back the parser up into its byte input

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (!holdoff_done && results_checked >= 3)
        begin
            holdoff_left <= 400;
            holdoff_done <= 1'b1;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        resp_ch.ready = 1'b0;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        wr_pos    = 0;
        frame_crc = CRC_INIT;

        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hFE);
        add_status_frame(ST_KEEPALIVE, 1'b0);
        add_status_frame(ST_THROTTLE, 1'b0);
        add_status_frame(ST_RETLOSS, 1'b0);
        add_status_frame(16'hFFFF, 1'b0);
        add_status_frame(ST_KEEPALIVE, 1'b1);
        add_plain_frame(LEN_STATUS, OP_TAG, 1'b0);
        add_plain_frame(LEN_TEMP, OP_TAG, 1'b0);
        add_plain_frame(0, 8'hFF, 1'b0);
        add_tag_frame(0, 32, 0, 1'b0, 8'h80);
        add_tag_frame(13, 37 * 8, 0, 1'b0, 8'h7F);
        add_tag_frame(0, 80, -4, 1'b0, -1);

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_pushed < 220)
        begin
            while (byte_q.size() > 64)
                @(posedge clk);
            add_random_frame();
        end

        while (bytes_taken != bytes_pushed)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- reader_response_frame_parser.f -----
rtl/rrfp_pkg.sv
rtl/rrfp_ifs.sv
rtl/rrfp_ram.sv
rtl/rrfp_intake.sv
rtl/rrfp_seq.sv
rtl/reader_response_frame_parser.sv
rtl/rrfp_checker.sv
bench/tb_top.sv
